>>> design/usrh_pkg.sv
// Shared types, codes and a helper function for the standard request handler.
package usrh_pkg;

    typedef enum logic [1:0] {
        ST_POWERED    = 2'd0,
        ST_DEFAULT    = 2'd1,
        ST_ADDRESS    = 2'd2,
        ST_CONFIGURED = 2'd3
    } t_dev_state;

    typedef enum logic [1:0] {
        EV_SETUP     = 2'd0,
        EV_DATA      = 2'd1,
        EV_STATUS    = 2'd2,
        EV_BUS_RESET = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        EP_NONE    = 2'd0,
        EP_ENABLE  = 2'd1,
        EP_DISABLE = 2'd2
    } t_ep_action;

    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    localparam logic [7:0] RT_STD_DEV_OUT  = 8'h00;
    localparam logic [7:0] RT_STD_IF_OUT   = 8'h01;
    localparam logic [7:0] RT_STD_DEV_IN   = 8'h80;
    localparam logic [7:0] RT_STD_IF_IN    = 8'h81;

    localparam logic [7:0]  DESC_DEVICE = 8'd1;
    localparam logic [7:0]  DESC_CONFIG = 8'd2;
    localparam logic [7:0]  DESC_STRING = 8'd3;
    localparam logic [15:0] LANG_EN_US  = 16'h0409;
    localparam logic [15:0] MAX_ADDRESS = 16'd127;
    localparam logic [15:0] SELF_POWERED_BIT = 16'd1;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_NUM  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IF_TOTAL    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CTRL_IF     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_IF   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_EP   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LIM  = 3'd5;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  request_type;
        logic [7:0]  opcode;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_request;

    typedef struct packed {
        logic        stall_res;
        logic [15:0] reply_length;
        logic [15:0] reply_bytes;
        logic        descriptor_fetch;
        logic [7:0]  descriptor_type;
        logic [7:0]  descriptor_number;
        logic        address_update;
        logic [6:0]  new_address;
        t_ep_action  endpoint_action;
        t_dev_state  device_state_now;
    } t_result;

    // recipient check shared by get status and clear feature
    function automatic logic recip_err(
        input logic [7:0]  rtype,
        input logic [7:0]  base,
        input logic [15:0] wi,
        input logic [4:0]  if_total,
        input t_dev_state  state,
        input logic [7:0]  ep_addr
    );
        logic err;
        err = 1'b1;
        if (rtype == base) begin
            err = (wi != 16'd0);
        end else if (rtype == (base | 8'd1)) begin
            err = (wi >= {11'd0, if_total}) || (state != ST_CONFIGURED);
        end else if (rtype == (base | 8'd2)) begin
            err = (wi != 16'd0) &&
                  ((state != ST_CONFIGURED) || (wi != {8'd0, ep_addr}));
        end
        return err;
    endfunction

endpackage

>>> design/usb_standard_request_handler_core.sv
// Standard request handler: device state, request checks and replies in one pass.
//
// Usage:
//   The slave stream takes one control event per beat: s_axis_tuser carries
//   the event kind (setup, data, status, bus reset) and s_axis_tdata the
//   setup packet fields. The master stream returns exactly one result beat
//   per event: m_axis_tuser is the stall flag, m_axis_tdata the reply length,
//   reply bytes, descriptor fetch request, address update, endpoint action
//   and the device state after the event.
//   An accepted beat lands in an input register, the decision logic works on
//   it and the result register presents the outcome. One beat per cycle is
//   sustained while the receiver does not stall; device state and the stream
//   endpoint flag are read and updated in that single decision stage, so
//   back-to-back events see each other's effects.
//   When the receiver stalls, the result holds, the input register keeps its
//   beat and s_axis_tready drops once both are full.
//   The configuration port writes one register per cycle; write it only
//   while no beat is in flight. Reset clears both stages, puts the device in
//   powered state, disables the stream endpoint and loads register defaults.
module usb_standard_request_handler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [usrh_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [usrh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] request_type, [15:8] opcode, [31:16] request_value,
    // [47:32] request_index, [63:48] request_length
    input  logic [63:0]                         s_axis_tdata,
    // [1:0] event_kind
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] reply_length, [31:16] reply_bytes, [32] descriptor_fetch,
    // [40:33] descriptor_type, [48:41] descriptor_number, [49] address_update,
    // [56:50] new_address, [58:57] endpoint_action, [60:59] device_state_now,
    // [63:61] zero
    output logic [63:0]                         m_axis_tdata,
    // [0] stall_res
    output logic                                m_axis_tuser
);

    logic                 r_in_valid;
    logic                 r_out_valid;
    usrh_pkg::t_request   r_req;
    usrh_pkg::t_result    r_res;
    usrh_pkg::t_result    n_res;
    usrh_pkg::t_dev_state r_state;
    usrh_pkg::t_dev_state n_state;
    logic                 r_ep_on;
    logic                 n_ep_on;

    logic [7:0] r_cfg_num;
    logic [4:0] r_if_total;
    logic [3:0] r_ctrl_if;
    logic [3:0] r_stream_if;
    logic [7:0] r_stream_ep;
    logic [7:0] r_string_lim;

    logic w_advance;
    logic w_in_fire;
    logic w_setup_err;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= usrh_pkg::ST_POWERED;
            r_ep_on      <= 1'b0;
            r_cfg_num    <= 8'd1;
            r_if_total   <= 5'd2;
            r_ctrl_if    <= 4'd0;
            r_stream_if  <= 4'd1;
            r_stream_ep  <= 8'd129;
            r_string_lim <= 8'd3;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_ep_on     <= n_ep_on;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    usrh_pkg::CFG_CONFIG_NUM: r_cfg_num    <= i_cfg_data;
                    usrh_pkg::CFG_IF_TOTAL:   r_if_total   <= i_cfg_data[4:0];
                    usrh_pkg::CFG_CTRL_IF:    r_ctrl_if    <= i_cfg_data[3:0];
                    usrh_pkg::CFG_STREAM_IF:  r_stream_if  <= i_cfg_data[3:0];
                    usrh_pkg::CFG_STREAM_EP:  r_stream_ep  <= i_cfg_data;
                    usrh_pkg::CFG_STRING_LIM: r_string_lim <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req.event_kind     <= s_axis_tuser;
            r_req.request_type   <= s_axis_tdata[7:0];
            r_req.opcode         <= s_axis_tdata[15:8];
            r_req.request_value  <= s_axis_tdata[31:16];
            r_req.request_index  <= s_axis_tdata[47:32];
            r_req.request_length <= s_axis_tdata[63:48];
        end
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    // setup-stage check
    always_comb begin
        logic [7:0]  rt;
        logic [15:0] wv;
        logic [15:0] wi;
        logic [15:0] wl;
        logic [7:0]  dt;
        logic [7:0]  idx;
        rt = r_req.request_type;
        wv = r_req.request_value;
        wi = r_req.request_index;
        wl = r_req.request_length;
        dt = wv[15:8];
        idx = wv[7:0];
        w_setup_err = 1'b1;
        case (r_req.opcode)
            usrh_pkg::REQ_GET_DESCRIPTOR: begin
                if (rt == usrh_pkg::RT_STD_DEV_IN) begin
                    if (dt == usrh_pkg::DESC_DEVICE || dt == usrh_pkg::DESC_CONFIG) begin
                        w_setup_err = (idx != 8'd0) || (wi != 16'd0);
                    end else if (dt == usrh_pkg::DESC_STRING) begin
                        w_setup_err = ((idx == 8'd0) && (wi != 16'd0)) ||
                                      ((idx != 8'd0) && (wi != usrh_pkg::LANG_EN_US)) ||
                                      (idx > r_string_lim);
                    end
                end
            end
            usrh_pkg::REQ_GET_CONFIGURATION: begin
                if (rt == usrh_pkg::RT_STD_DEV_IN) begin
                    w_setup_err = (wv != 16'd0) || (wi != 16'd0) || (wl != 16'd1) ||
                                  (r_state == usrh_pkg::ST_DEFAULT);
                end
            end
            usrh_pkg::REQ_GET_INTERFACE: begin
                if (rt == usrh_pkg::RT_STD_IF_IN) begin
                    w_setup_err = (wi >= {11'd0, r_if_total}) ||
                                  (r_state == usrh_pkg::ST_ADDRESS) ||
                                  (wv != 16'd0) || (wl != 16'd1) ||
                                  (r_state == usrh_pkg::ST_DEFAULT);
                end
            end
            usrh_pkg::REQ_GET_STATUS: begin
                w_setup_err = usrh_pkg::recip_err(rt, usrh_pkg::RT_STD_DEV_IN, wi,
                                                  r_if_total, r_state, r_stream_ep) ||
                              (wv != 16'd0) || (wl != 16'd2) ||
                              (r_state == usrh_pkg::ST_DEFAULT);
            end
            usrh_pkg::REQ_SET_ADDRESS: begin
                if (rt == usrh_pkg::RT_STD_DEV_OUT) begin
                    w_setup_err = (wv > usrh_pkg::MAX_ADDRESS) || (wi != 16'd0) ||
                                  (wl != 16'd0) || (r_state == usrh_pkg::ST_CONFIGURED);
                end
            end
            usrh_pkg::REQ_SET_CONFIGURATION: begin
                if (rt == usrh_pkg::RT_STD_DEV_OUT) begin
                    w_setup_err = ((wv != 16'd0) && (wv != {8'd0, r_cfg_num})) ||
                                  (wi != 16'd0) || (wl != 16'd0) ||
                                  (r_state == usrh_pkg::ST_DEFAULT);
                end
            end
            usrh_pkg::REQ_SET_INTERFACE: begin
                if (rt == usrh_pkg::RT_STD_IF_OUT && r_state != usrh_pkg::ST_ADDRESS) begin
                    if (wi == {12'd0, r_ctrl_if}) begin
                        w_setup_err = (wv != 16'd0);
                    end else if (wi == {12'd0, r_stream_if}) begin
                        w_setup_err = (wv > 16'd1);
                    end
                    w_setup_err = w_setup_err ||
                                  !((wi == {12'd0, r_ctrl_if}) ||
                                    (wi == {12'd0, r_stream_if})) ||
                                  (wl != 16'd0) || (r_state == usrh_pkg::ST_DEFAULT);
                end
            end
            usrh_pkg::REQ_CLEAR_FEATURE: begin
                w_setup_err = usrh_pkg::recip_err(rt, usrh_pkg::RT_STD_DEV_OUT, wi,
                                                  r_if_total, r_state, r_stream_ep) ||
                              (wl != 16'd0) || (r_state == usrh_pkg::ST_DEFAULT);
            end
            default: w_setup_err = 1'b1;
        endcase
    end

    // event execution, next state and result
    always_comb begin
        logic        is_in;
        logic [15:0] wv;
        logic [15:0] wi;
        is_in   = r_req.request_type[7];
        wv      = r_req.request_value;
        wi      = r_req.request_index;
        n_state = r_state;
        n_ep_on = r_ep_on;
        n_res   = '0;
        n_res.endpoint_action = usrh_pkg::EP_NONE;
        if (r_req.event_kind == usrh_pkg::EV_BUS_RESET) begin
            n_state = usrh_pkg::ST_DEFAULT;
            n_ep_on = 1'b0;
        end else if (r_req.request_type[6:5] != 2'd0) begin
            n_res.stall_res = 1'b1;
        end else if (r_req.event_kind == usrh_pkg::EV_SETUP) begin
            if (w_setup_err) begin
                n_res.stall_res = 1'b1;
            end else if (is_in) begin
                case (r_req.opcode)
                    usrh_pkg::REQ_GET_DESCRIPTOR: begin
                        n_res.descriptor_fetch  = 1'b1;
                        n_res.descriptor_type   = wv[15:8];
                        n_res.descriptor_number = wv[7:0];
                        n_res.reply_length      = r_req.request_length;
                    end
                    usrh_pkg::REQ_GET_CONFIGURATION: begin
                        n_res.reply_length = 16'd1;
                        n_res.reply_bytes  = (r_state == usrh_pkg::ST_ADDRESS) ?
                                             16'd0 : {8'd0, r_cfg_num};
                    end
                    usrh_pkg::REQ_GET_INTERFACE: begin
                        n_res.reply_length = 16'd1;
                        n_res.reply_bytes  = {15'd0,
                                              (wi == {12'd0, r_stream_if}) && r_ep_on};
                    end
                    usrh_pkg::REQ_GET_STATUS: begin
                        n_res.reply_length = 16'd2;
                        n_res.reply_bytes  = (r_req.request_type[4:0] == 5'd0) ?
                                             usrh_pkg::SELF_POWERED_BIT : 16'd0;
                    end
                    default: ;
                endcase
            end
        end else if (r_req.event_kind == usrh_pkg::EV_STATUS && !is_in) begin
            case (r_req.opcode)
                usrh_pkg::REQ_SET_ADDRESS: begin
                    if (r_state == usrh_pkg::ST_DEFAULT && wv != 16'd0) begin
                        n_state = usrh_pkg::ST_ADDRESS;
                    end else if (r_state == usrh_pkg::ST_ADDRESS && wv == 16'd0) begin
                        n_state = usrh_pkg::ST_DEFAULT;
                    end
                    n_res.address_update = 1'b1;
                    n_res.new_address    = wv[6:0];
                end
                usrh_pkg::REQ_SET_CONFIGURATION: begin
                    if (r_state == usrh_pkg::ST_ADDRESS && wv != 16'd0) begin
                        n_state = usrh_pkg::ST_CONFIGURED;
                    end else if (r_state == usrh_pkg::ST_CONFIGURED && wv == 16'd0) begin
                        n_state = usrh_pkg::ST_ADDRESS;
                    end
                    if (r_ep_on) begin
                        n_ep_on = 1'b0;
                        n_res.endpoint_action = usrh_pkg::EP_DISABLE;
                    end
                end
                usrh_pkg::REQ_SET_INTERFACE: begin
                    if (wv != 16'd0) begin
                        if (!r_ep_on) begin
                            n_ep_on = 1'b1;
                            n_res.endpoint_action = usrh_pkg::EP_ENABLE;
                        end
                    end else if (wi == {12'd0, r_stream_if} && r_ep_on) begin
                        n_ep_on = 1'b0;
                        n_res.endpoint_action = usrh_pkg::EP_DISABLE;
                    end
                end
                usrh_pkg::REQ_CLEAR_FEATURE,
                usrh_pkg::REQ_GET_STATUS,
                usrh_pkg::REQ_GET_DESCRIPTOR,
                usrh_pkg::REQ_GET_CONFIGURATION,
                usrh_pkg::REQ_GET_INTERFACE: ;
                default: n_res.stall_res = 1'b1;
            endcase
        end
        n_res.device_state_now = n_state;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.stall_res;
    assign m_axis_tdata  = {3'd0,
                            r_res.device_state_now,
                            r_res.endpoint_action,
                            r_res.new_address,
                            r_res.address_update,
                            r_res.descriptor_number,
                            r_res.descriptor_type,
                            r_res.descriptor_fetch,
                            r_res.reply_bytes,
                            r_res.reply_length};

    a_action_not_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.endpoint_action != usrh_pkg::EP_NONE) |-> !r_res.stall_res)
        else $error("endpoint action on a stalled result");

    a_enable_tracks_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.endpoint_action == usrh_pkg::EP_ENABLE) |-> r_ep_on)
        else $error("endpoint enable reported but flag clear");

    a_state_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.device_state_now == r_state))
        else $error("reported device state differs from state register");

    a_state_held_idle: assert property (@(posedge i_clk)
        i_rst_n && !w_advance |=> $stable(r_ep_on) && $stable(r_state))
        else $error("state changed without a beat");

endmodule
